FILE: rtl/core/scmu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scmu_pkg
// Shared types, sizes and codes of the segmented checked memory unit.
// ----------------------------------------------------------------------------
package scmu_pkg;

    localparam int CODE_STORE_BYTES   = 1024;
    localparam int DATA_STORE_BYTES   = 1024;
    localparam int STATIC_STORE_BYTES = 1024;

    localparam int CA_W = (CODE_STORE_BYTES > 1) ? $clog2(CODE_STORE_BYTES) : 1;
    localparam int DA_W = (DATA_STORE_BYTES > 1) ? $clog2(DATA_STORE_BYTES) : 1;
    localparam int SA_W = (STATIC_STORE_BYTES > 1) ? $clog2(STATIC_STORE_BYTES) : 1;

    // The data top always stays below the data store size.
    localparam int DT_W = $clog2(DATA_STORE_BYTES);

    localparam int CLR_DEPTH = (CODE_STORE_BYTES > DATA_STORE_BYTES) ?
                               CODE_STORE_BYTES : DATA_STORE_BYTES;
    localparam int CLR_W     = $clog2(CLR_DEPTH);

    localparam int CFG_W  = 11;
    localparam int OFF_W  = 14;
    localparam int LIM_W  = 15;
    localparam int SUM_W  = 17;

    localparam logic [15:0] SEG_DATA_TAG = 16'h4000;

    localparam logic [2:0] OP_READ_BYTE   = 3'd0;
    localparam logic [2:0] OP_WRITE_BYTE  = 3'd1;
    localparam logic [2:0] OP_READ_WORD   = 3'd2;
    localparam logic [2:0] OP_WRITE_WORD  = 3'd3;
    localparam logic [2:0] OP_ALLOT       = 3'd4;
    localparam logic [2:0] OP_HERE        = 3'd5;
    localparam logic [2:0] OP_LOAD_STATIC = 3'd6;

    localparam logic [2:0] ERR_OK           = 3'd0;
    localparam logic [2:0] ERR_DATA_BEYOND  = 3'd1;
    localparam logic [2:0] ERR_CODE_BEYOND  = 3'd2;
    localparam logic [2:0] ERR_WRITE_STATIC = 3'd3;
    localparam logic [2:0] ERR_DATA_OVERFLOW = 3'd4;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] address;
        logic [15:0] data_in;
    } cmd_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic [2:0]  error_code;
    } result_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIRST,
        ST_SECOND,
        ST_REPLY
    } state_t;

    // Where the byte of the current access comes from.
    typedef enum logic [2:0] {
        SRC_DATA,
        SRC_CODE,
        SRC_STATIC,
        SRC_FF,
        SRC_ZERO
    } src_t;

    typedef struct packed {
        logic [2:0]       err;
        src_t             src;
        logic [OFF_W-1:0] idx;
    } byte_chk_t;

    typedef struct packed {
        logic             we;
        logic [OFF_W-1:0] addr;
        logic [7:0]       wdata;
    } ram_req_t;

endpackage

FILE: rtl/core/scmu_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scmu_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module scmu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                          wdata,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/scmu_byte_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scmu_byte_decode
// Bounds check and store mapping of one tagged byte address.
// ----------------------------------------------------------------------------
module scmu_byte_decode import scmu_pkg::*; (
    input  logic [15:0]      address,
    input  logic             is_write,
    input  logic [DT_W-1:0]  data_top,
    input  logic [CFG_W-1:0] scb,
    output byte_chk_t        chk
);

    logic [OFF_W-1:0] off;
    logic [LIM_W-1:0] code_limit;
    logic             below_static;

    assign off          = address[OFF_W-1:0];
    assign code_limit   = LIM_W'(CODE_STORE_BYTES) + LIM_W'(scb);
    assign below_static = off < OFF_W'(scb);

    always_comb
    begin
        chk.err = ERR_OK;
        chk.src = SRC_FF;
        chk.idx = off;
        if (address[14])
        begin
            if (LIM_W'(off) >= LIM_W'(data_top))
            begin
                chk.err = ERR_DATA_BEYOND;
            end
            else
            begin
                chk.src = SRC_DATA;
            end
        end
        else if (LIM_W'(off) >= code_limit)
        begin
            chk.err = ERR_CODE_BEYOND;
        end
        else if (below_static)
        begin
            if (is_write)
            begin
                chk.err = ERR_WRITE_STATIC;
            end
            else if (32'(off) < STATIC_STORE_BYTES)
            begin
                chk.src = SRC_STATIC;
            end
            else
            begin
                chk.src = SRC_ZERO;
            end
        end
        else
        begin
            chk.src = SRC_CODE;
            chk.idx = off - OFF_W'(scb);
        end
    end

endmodule

FILE: rtl/core/scmu_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scmu_seq
// Sequencer: clears the data and code stores after reset, then runs each
// command, with byte and word accesses as one or two byte accesses to the RAMs, and forms the result word.
// ----------------------------------------------------------------------------
module scmu_seq import scmu_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  cmd_t             cmd,
    input  logic             cfg_write,
    input  logic [CFG_W-1:0] cfg_data,
    output logic             done,
    output result_t          result,
    output ram_req_t         data_req,
    output ram_req_t         code_req,
    output ram_req_t         static_req,
    input  logic [7:0]       data_rdata,
    input  logic [7:0]       code_rdata,
    input  logic [7:0]       static_rdata
);

    localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLR_DEPTH - 1);

    state_t           state_reg, state_next;
    logic [CLR_W-1:0] clr_cnt_reg, clr_cnt_next;
    cmd_t             cmd_reg, cmd_next;
    logic [2:0]       err_reg, err_next;
    src_t             src_reg, src_next;
    logic [7:0]       hi_reg, hi_next;
    logic [DT_W-1:0]  top_reg, top_next;
    logic [CFG_W-1:0] scb_reg, scb_next;
    result_t          result_reg, result_next;
    logic             done_reg, done_next;

    logic [15:0]      dec_addr;
    logic             dec_write;
    byte_chk_t        chk;
    logic [7:0]       cur_byte;
    logic [SUM_W-1:0] allot_sum;

    scmu_byte_decode u_dec (
        .address  (dec_addr),
        .is_write (dec_write),
        .data_top (top_reg),
        .scb      (scb_reg),
        .chk      (chk)
    );

    // Byte delivered by the RAM access issued in the previous cycle.
    always_comb
    begin
        case (src_reg)
            SRC_DATA:   cur_byte = data_rdata;
            SRC_CODE:   cur_byte = code_rdata;
            SRC_STATIC: cur_byte = static_rdata;
            SRC_FF:     cur_byte = 8'hFF;
            default:    cur_byte = 8'h00;
        endcase
    end

    assign allot_sum = SUM_W'(top_reg) + SUM_W'(cmd_reg.data_in);
    assign dec_write = (cmd_reg.op == OP_WRITE_BYTE) || (cmd_reg.op == OP_WRITE_WORD);
    assign dec_addr  = (state_reg == ST_SECOND) ? (cmd_reg.address + 16'd1)
                                                : cmd_reg.address;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_FIRST;
                end
            end
            ST_FIRST:
            begin
                if ((cmd_reg.op == OP_READ_WORD) || (cmd_reg.op == OP_WRITE_WORD))
                begin
                    state_next = ST_SECOND;
                end
                else
                begin
                    state_next = ST_REPLY;
                end
            end
            ST_SECOND:
            begin
                state_next = ST_REPLY;
            end
            ST_REPLY:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        cmd_next     = cmd_reg;
        err_next     = err_reg;
        src_next     = src_reg;
        hi_next      = hi_reg;
        top_next     = top_reg;
        scb_next     = cfg_write ? cfg_data : scb_reg;
        result_next  = result_reg;
        done_next    = 1'b0;

        data_req       = '0;
        code_req       = '0;
        static_req     = '0;
        data_req.addr   = chk.idx;
        code_req.addr   = chk.idx;
        static_req.addr = chk.idx;

        unique case (state_reg)
            ST_CLEAR:
            begin
                data_req.addr = OFF_W'(clr_cnt_reg);
                code_req.addr = OFF_W'(clr_cnt_reg);
                data_req.we   = 32'(clr_cnt_reg) < DATA_STORE_BYTES;
                code_req.we   = 32'(clr_cnt_reg) < CODE_STORE_BYTES;
                clr_cnt_next  = clr_cnt_reg + CLR_W'(1);
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                end
            end
            ST_FIRST:
            begin
                err_next = ERR_OK;
                src_next = chk.src;
                case (cmd_reg.op) inside
                    OP_READ_BYTE, OP_READ_WORD:
                    begin
                        err_next = chk.err;
                    end
                    OP_WRITE_BYTE, OP_WRITE_WORD:
                    begin
                        err_next = chk.err;
                        data_req.wdata = (cmd_reg.op == OP_WRITE_BYTE) ?
                                         cmd_reg.data_in[7:0] : cmd_reg.data_in[15:8];
                        code_req.wdata = data_req.wdata;
                        if (chk.err == ERR_OK)
                        begin
                            data_req.we = chk.src == SRC_DATA;
                            code_req.we = chk.src == SRC_CODE;
                        end
                    end
                    OP_ALLOT:
                    begin
                        if (allot_sum >= SUM_W'(DATA_STORE_BYTES))
                        begin
                            err_next = ERR_DATA_OVERFLOW;
                        end
                        else
                        begin
                            top_next = allot_sum[DT_W-1:0];
                        end
                    end
                    OP_LOAD_STATIC:
                    begin
                        static_req.addr  = cmd_reg.address[OFF_W-1:0];
                        static_req.wdata = cmd_reg.data_in[7:0];
                        static_req.we    = 32'(cmd_reg.address) < STATIC_STORE_BYTES;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_SECOND:
            begin
                hi_next = cur_byte;
                // Once the first byte has failed, the second one fails too.
                if (err_reg == ERR_OK)
                begin
                    err_next = chk.err;
                    src_next = chk.src;
                    data_req.wdata = cmd_reg.data_in[7:0];
                    code_req.wdata = cmd_reg.data_in[7:0];
                    if ((cmd_reg.op == OP_WRITE_WORD) && (chk.err == ERR_OK))
                    begin
                        data_req.we = chk.src == SRC_DATA;
                        code_req.we = chk.src == SRC_CODE;
                    end
                end
                else
                begin
                    src_next = SRC_FF;
                end
            end
            ST_REPLY:
            begin
                done_next              = 1'b1;
                result_next.read_data  = 16'h0000;
                result_next.error_code = err_reg;
                case (cmd_reg.op) inside
                    OP_READ_BYTE:
                    begin
                        result_next.read_data = {8'h00, cur_byte};
                    end
                    OP_READ_WORD:
                    begin
                        result_next.read_data = {hi_reg, cur_byte};
                    end
                    OP_HERE:
                    begin
                        result_next.read_data = 16'(top_reg) | SEG_DATA_TAG;
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            top_reg     <= '0;
            scb_reg     <= '0;
            done_reg    <= 1'b0;
            err_reg     <= ERR_OK;
            src_reg     <= SRC_ZERO;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            top_reg     <= top_next;
            scb_reg     <= scb_next;
            done_reg    <= done_next;
            err_reg     <= err_next;
            src_reg     <= src_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        hi_reg     <= hi_next;
        result_reg <= result_next;
    end

    assign busy   = state_reg != ST_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: rtl/core/segmented_checked_memory_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segmented_checked_memory_unit
// Bounds-checked byte and word access to data, code and static stores.
// ----------------------------------------------------------------------------
// Byte, allot, here and static-load commands run through FIRST and REPLY, word
// commands through FIRST, SECOND and REPLY (one RAM access per byte); done and
// the result word are registered together on leaving REPLY and show together.
// A new command may start in the cycle that done is high; none is taken while
// busy is high. Results must be taken when shown.
// Reset: a clearing pass over every address zeroes the data and code stores with
// busy high; configuration writes are taken during it.
module segmented_checked_memory_unit import scmu_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  cmd_t             cmd,
    input  logic             cfg_write,
    input  logic [CFG_W-1:0] cfg_data,
    output logic             done,
    output result_t          result
);

    ram_req_t   data_req, code_req, static_req;
    logic [7:0] data_rdata, code_rdata, static_rdata;

    scmu_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .done         (done),
        .result       (result),
        .data_req     (data_req),
        .code_req     (code_req),
        .static_req   (static_req),
        .data_rdata   (data_rdata),
        .code_rdata   (code_rdata),
        .static_rdata (static_rdata)
    );

    scmu_ram #(.WIDTH(8), .DEPTH(DATA_STORE_BYTES)) u_data_ram (
        .clk   (clk),
        .we    (data_req.we),
        .addr  (data_req.addr[DA_W-1:0]),
        .wdata (data_req.wdata),
        .rdata (data_rdata)
    );

    scmu_ram #(.WIDTH(8), .DEPTH(CODE_STORE_BYTES)) u_code_ram (
        .clk   (clk),
        .we    (code_req.we),
        .addr  (code_req.addr[CA_W-1:0]),
        .wdata (code_req.wdata),
        .rdata (code_rdata)
    );

    scmu_ram #(.WIDTH(8), .DEPTH(STATIC_STORE_BYTES)) u_static_ram (
        .clk   (clk),
        .we    (static_req.we),
        .addr  (static_req.addr[SA_W-1:0]),
        .wdata (static_req.wdata),
        .rdata (static_rdata)
    );

endmodule

FILE: rtl/core/scmu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scmu_checker
// Port-level checks of the memory unit's command and result timing and error codes.
// ----------------------------------------------------------------------------
module scmu_checker import scmu_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input result_t          result
);

    // An accepted command makes the unit busy at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("unit not busy after accepting a command");

    // No result shows up right after a command is accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (!done ##1 !done))
        else $error("result word appeared too early");

    // A result is shown for a single cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

    // The unit is ready again when it delivers a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("unit still busy while delivering a result");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((result.error_code == ERR_OK) ||
                  (result.error_code == ERR_DATA_BEYOND) ||
                  (result.error_code == ERR_CODE_BEYOND) ||
                  (result.error_code == ERR_WRITE_STATIC) ||
                  (result.error_code == ERR_DATA_OVERFLOW)))
        else $error("result word carries an unknown error code");

endmodule

bind segmented_checked_memory_unit scmu_checker u_scmu_checker (.*);

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the segmented checked memory unit. A queue of
// commands feeds a bursty driver; each accepted word is run through a
// behavioral copy of the data, code and static stores, and the monitor
// compares every strobed result with the oldest prediction. The static
// region size is swept over several values, the extremes among them.
// ----------------------------------------------------------------------------
module tb_top;
    import scmu_pkg::*;

    localparam logic [2:0] OP_UNUSED = 3'd7;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    cmd_t             cmd = '0;
    logic             cfg_write = 1'b0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             done;
    result_t          result;

    segmented_checked_memory_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    cmd_t        pending_cmds[$];
    result_t     due_results[$];
    int          mismatch_count = 0;

    // Behavioral copy of the unit.
    logic [7:0]  data_mem   [DATA_STORE_BYTES];
    logic [7:0]  code_mem   [CODE_STORE_BYTES];
    logic [7:0]  static_mem [STATIC_STORE_BYTES];
    int unsigned top_now = 0;
    int unsigned static_bytes = 0;

    // Generator side: which static entries have been loaded so far.
    bit          gen_loaded [STATIC_STORE_BYTES];
    int unsigned gen_static_bytes = 0;
    logic [15:0] last_addr = 16'h4000;

    int          burst_left = 1;
    int          gap_left = 0;

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic logic [2:0] check_access(input logic [15:0] a, input bit wr);
        int unsigned off;
        off = a[13:0];
        if (a[14])
            return (off >= top_now) ? ERR_DATA_BEYOND : ERR_OK;
        if (off >= CODE_STORE_BYTES + static_bytes)
            return ERR_CODE_BEYOND;
        if (wr && off < static_bytes)
            return ERR_WRITE_STATIC;
        return ERR_OK;
    endfunction

    function automatic logic [7:0] fetch_byte(input logic [15:0] a, output logic [2:0] err);
        int unsigned off;
        off = a[13:0];
        err = check_access(a, 1'b0);
        if (err != ERR_OK)
            return 8'hFF;
        if (a[14])
            return (off < DATA_STORE_BYTES) ? data_mem[off] : 8'h00;
        if (off < static_bytes)
            return (off < STATIC_STORE_BYTES) ? static_mem[off] : 8'h00;
        off -= static_bytes;
        return (off < CODE_STORE_BYTES) ? code_mem[off] : 8'h00;
    endfunction

    task automatic store_byte(input logic [15:0] a, input logic [7:0] b,
                              output logic [2:0] err);
        int unsigned off;
        off = a[13:0];
        err = check_access(a, 1'b1);
        if (err == ERR_OK)
        begin
            if (a[14])
            begin
                if (off < DATA_STORE_BYTES)
                    data_mem[off] = b;
            end
            else
            begin
                off -= static_bytes;
                if (off < CODE_STORE_BYTES)
                    code_mem[off] = b;
            end
        end
    endtask

    task automatic compute_result(input cmd_t c);
        result_t     r;
        logic [2:0]  err;
        logic [2:0]  err2;
        logic [7:0]  hi;
        logic [7:0]  lo;
        logic [15:0] next_a;
        r = '0;
        err = ERR_OK;
        err2 = ERR_OK;
        next_a = c.address + 16'd1;
        case (c.op)
            OP_READ_BYTE:
            begin
                lo = fetch_byte(c.address, err);
                r.read_data = {8'h00, lo};
            end
            OP_WRITE_BYTE:
                store_byte(c.address, c.data_in[7:0], err);
            OP_READ_WORD:
            begin
                hi = fetch_byte(c.address, err);
                // A failed first byte makes the second fail too.
                if (err != ERR_OK)
                    lo = 8'hFF;
                else
                begin
                    lo = fetch_byte(next_a, err2);
                    err = err2;
                end
                r.read_data = {hi, lo};
            end
            OP_WRITE_WORD:
            begin
                store_byte(c.address, c.data_in[15:8], err);
                if (err == ERR_OK)
                    store_byte(next_a, c.data_in[7:0], err);
            end
            OP_ALLOT:
            begin
                if (top_now + c.data_in >= DATA_STORE_BYTES)
                    err = ERR_DATA_OVERFLOW;
                else
                    top_now = top_now + c.data_in;
            end
            OP_HERE:
                r.read_data = SEG_DATA_TAG | 16'(top_now);
            OP_LOAD_STATIC:
            begin
                if (c.address < STATIC_STORE_BYTES)
                    static_mem[c.address] = c.data_in[7:0];
            end
            default:
                ;
        endcase
        r.error_code = err;
        due_results.push_back(r);
    endtask

    // A code read below the static size must never hit a static entry that
    // was never loaded, so such an entry is loaded just ahead of the read.
    task automatic guard_static(input logic [15:0] a);
        cmd_t ld;
        if (!a[14] && a[13:0] < gen_static_bytes && !gen_loaded[a[13:0]])
        begin
            ld.op = OP_LOAD_STATIC;
            ld.address = 16'(a[13:0]);
            ld.data_in = 16'($urandom);
            gen_loaded[a[13:0]] = 1'b1;
            pending_cmds.push_back(ld);
        end
    endtask

    task automatic queue_cmd(input logic [2:0] op, input logic [15:0] a,
                             input logic [15:0] d);
        cmd_t c;
        if (op == OP_READ_BYTE || op == OP_READ_WORD)
        begin
            guard_static(a);
            if (op == OP_READ_WORD)
                guard_static(a + 16'd1);
        end
        if (op == OP_LOAD_STATIC && a < STATIC_STORE_BYTES)
            gen_loaded[a] = 1'b1;
        c.op = op;
        c.address = a;
        c.data_in = d;
        pending_cmds.push_back(c);
    endtask

    function automatic logic [15:0] pick_address();
        int          r;
        logic [15:0] a;
        r = $urandom_range(0, 99);
        if (r < 20)
            a = last_addr + 16'($urandom_range(0, 1));
        else if (r < 55)
            a = {1'($urandom), 1'b1, 14'($urandom_range(0, 1040))};
        else if (r < 90)
            a = {1'($urandom), 1'b0, 14'($urandom_range(0, 2100))};
        else
            a = 16'($urandom);
        last_addr = a;
        return a;
    endfunction

    function automatic logic [2:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return OP_READ_BYTE;
        else if (r < 40)
            return OP_WRITE_BYTE;
        else if (r < 55)
            return OP_READ_WORD;
        else if (r < 70)
            return OP_WRITE_WORD;
        else if (r < 78)
            return OP_ALLOT;
        else if (r < 82)
            return OP_HERE;
        else if (r < 95)
            return OP_LOAD_STATIC;
        return OP_UNUSED;
    endfunction

    task automatic add_random_items(input int n);
        int          made;
        bit          as_word;
        logic [2:0]  op;
        logic [15:0] a;
        logic [15:0] d;
        made = 0;
        while (made < n)
        begin
            if ($urandom_range(0, 99) < 30)
            begin
                // Write followed by a read back of the same place.
                as_word = 1'($urandom);
                a = pick_address();
                queue_cmd(as_word ? OP_WRITE_WORD : OP_WRITE_BYTE, a, 16'($urandom));
                queue_cmd(as_word ? OP_READ_WORD : OP_READ_BYTE, a, 16'($urandom));
                made += 2;
            end
            else
            begin
                op = pick_op();
                d = 16'($urandom);
                if (op == OP_ALLOT)
                begin
                    if ($urandom_range(0, 99) < 85)
                        d = 16'($urandom_range(0, 24));
                    a = 16'($urandom);
                end
                else if (op == OP_LOAD_STATIC)
                begin
                    if ($urandom_range(0, 99) < 80)
                        a = 16'($urandom_range(0, STATIC_STORE_BYTES - 1));
                    else
                        a = 16'($urandom);
                end
                else if (op == OP_HERE || op == OP_UNUSED)
                    a = 16'($urandom);
                else
                    a = pick_address();
                queue_cmd(op, a, d);
                if (op != OP_UNUSED)
                    made++;
            end
        end
    endtask

    task automatic wait_for_drain(input int limit);
        int n;
        n = 0;
        @(negedge clk);
        while (!(pending_cmds.size() == 0 && !start && due_results.size() == 0
                 && !busy) && n < limit)
        begin
            @(negedge clk);
            n++;
        end
    endtask

    task automatic set_static_size(input int unsigned v);
        wait_for_drain(40000);
        repeat (6) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= CFG_W'(v);
        @(posedge clk);
        cfg_write <= 1'b0;
        static_bytes = v;
        gen_static_bytes = v;
        @(negedge clk);
    endtask

    // Driver: a new word may be presented whenever the current one is taken
    // or none is shown.
    always @(posedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            if (start && !busy)
                compute_result(cmd);
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    cmd <= pending_cmds.pop_front();
                    start <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        if ($urandom_range(0, 7) == 0)
                            burst_left = $urandom_range(40, 80);
                        else
                            burst_left = $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end
                else
                    start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (due_results.size() == 0)
                report_mismatch($sformatf("unexpected result data=0x%h err=%0d",
                                          result.read_data, result.error_code));
            else
            begin
                if (result.read_data !== due_results[0].read_data)
                    report_mismatch($sformatf("read_data 0x%h, expected 0x%h",
                                              result.read_data, due_results[0].read_data));
                if (result.error_code !== due_results[0].error_code)
                    report_mismatch($sformatf("error_code %0d, expected %0d",
                                              result.error_code, due_results[0].error_code));
                void'(due_results.pop_front());
            end
        end
    end

    initial
    begin
        foreach (data_mem[i])
            data_mem[i] = 8'h00;
        foreach (code_mem[i])
            code_mem[i] = 8'h00;
        foreach (static_mem[i])
            static_mem[i] = 8'h00;
        foreach (gen_loaded[i])
            gen_loaded[i] = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // The clearing pass keeps busy high, so the first write waits for it.
        set_static_size(0);
        queue_cmd(OP_HERE, 16'h0000, 16'h0000);
        queue_cmd(OP_READ_BYTE, 16'h4000, 16'h0000);
        queue_cmd(OP_WRITE_BYTE, 16'h4000, 16'hFFFF);
        queue_cmd(OP_ALLOT, 16'hFFFF, 16'hFFFF);
        queue_cmd(OP_ALLOT, 16'h0000, 16'(DATA_STORE_BYTES));
        queue_cmd(OP_ALLOT, 16'h0000, 16'd16);
        queue_cmd(OP_ALLOT, 16'h0000, 16'd0);
        queue_cmd(OP_WRITE_BYTE, 16'h4000, 16'hFFFF);
        queue_cmd(OP_READ_BYTE, 16'h4000, 16'h0000);
        queue_cmd(OP_WRITE_WORD, 16'h4005, 16'hA55A);
        queue_cmd(OP_READ_WORD, 16'hC005, 16'h0000);
        // Word straddling the data top: second byte fails.
        queue_cmd(OP_READ_WORD, 16'h400F, 16'h0000);
        queue_cmd(OP_WRITE_WORD, 16'h400F, 16'h1234);
        queue_cmd(OP_READ_BYTE, 16'h400F, 16'h0000);
        queue_cmd(OP_WRITE_BYTE, 16'h0000, 16'h0012);
        queue_cmd(OP_READ_WORD, 16'h03FF, 16'h0000);
        queue_cmd(OP_WRITE_WORD, 16'h03FE, 16'hBEEF);
        queue_cmd(OP_READ_WORD, 16'h03FE, 16'h0000);
        queue_cmd(OP_READ_WORD, 16'hFFFF, 16'h0000);
        queue_cmd(OP_READ_WORD, 16'h3FFF, 16'h0000);
        queue_cmd(OP_READ_WORD, 16'h7FFF, 16'h0000);
        queue_cmd(OP_LOAD_STATIC, 16'h0000, 16'h00AB);
        queue_cmd(OP_LOAD_STATIC, 16'h03FF, 16'hFFCD);
        queue_cmd(OP_LOAD_STATIC, 16'hFFFF, 16'h5555);
        queue_cmd(OP_LOAD_STATIC, 16'(STATIC_STORE_BYTES), 16'h0055);
        queue_cmd(OP_UNUSED, 16'hFFFF, 16'hFFFF);
        queue_cmd(OP_HERE, 16'hFFFF, 16'hFFFF);

        set_static_size(CODE_STORE_BYTES);
        queue_cmd(OP_READ_BYTE, 16'h0000, 16'h0000);
        queue_cmd(OP_WRITE_BYTE, 16'h0000, 16'h0077);
        // First byte static, second byte in the writable code store.
        queue_cmd(OP_READ_WORD, 16'h03FF, 16'h0000);
        queue_cmd(OP_WRITE_WORD, 16'h03FF, 16'h1122);
        queue_cmd(OP_WRITE_BYTE, 16'h07FF, 16'h00FF);
        queue_cmd(OP_READ_BYTE, 16'h07FF, 16'h0000);
        queue_cmd(OP_READ_BYTE, 16'h0800, 16'h0000);
        queue_cmd(OP_READ_BYTE, 16'h8800, 16'h0000);
        add_random_items(145);

        set_static_size($urandom_range(2, CODE_STORE_BYTES - 2));
        add_random_items(145);
        set_static_size(1);
        add_random_items(145);
        set_static_size(CODE_STORE_BYTES - 1);
        add_random_items(145);
        set_static_size($urandom_range(2, CODE_STORE_BYTES - 2));
        add_random_items(145);
        set_static_size(0);
        add_random_items(145);
        set_static_size(CODE_STORE_BYTES);
        add_random_items(145);

        wait_for_drain(40000);
        repeat (8) @(posedge clk);
        if (due_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", due_results.size()));
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #(2_000_000);
        $display("Test completed with failures");
        $finish;
    end

endmodule
